/* src/cibs_pkg.sv */
`default_nettype none
package cibs_pkg;

  // square root: one result bit per stage, 32-bit root of a 64-bit radicand
  localparam int SQRT_STAGES = 32;

  // division: one quotient bit per stage, 31-bit quotient
  localparam int DIV_STAGES = 31;

endpackage
`default_nettype wire

/* src/cibs_sqrt.sv */
`default_nettype none
// Pipelined integer square root, floor(sqrt(radicand)).
// One root bit is settled per stage, most significant bit first.
module cibs_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  localparam int N = cibs_pkg::SQRT_STAGES;

  logic [63:0] rem_q [1:N-1];
  logic [31:0] rt_q  [1:N];
  logic [63:0] rem_in [0:N-1];
  logic [31:0] rt_in  [0:N-1];
  logic [63:0] rem_n  [0:N-1];
  logic [31:0] rt_n   [0:N-1];

  // try each root bit against the running remainder
  always_comb begin
    logic [65:0] trial;
    rem_in[0] = radicand;
    rt_in[0]  = '0;
    for (int i = 1; i < N; i++) begin
      rem_in[i] = rem_q[i];
      rt_in[i]  = rt_q[i];
    end
    for (int i = 0; i < N; i++) begin
      trial = ({34'd0, rt_in[i]} << (N - i)) + (66'd1 << (2 * (N - 1 - i)));
      if ({2'b00, rem_in[i]} >= trial) begin
        rem_n[i] = rem_in[i] - trial[63:0];
        rt_n[i]  = rt_in[i] | (32'd1 << (N - 1 - i));
      end else begin
        rem_n[i] = rem_in[i];
        rt_n[i]  = rt_in[i];
      end
    end
  end

  // advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rt_q[i+1] <= rt_n[i];
        if (i < N - 1) begin
          rem_q[i+1] <= rem_n[i];
        end
      end
    end
  end

  assign root = rt_q[N];

endmodule
`default_nettype wire

/* src/cibs_div.sv */
`default_nettype none
// Pipelined restoring divider. The top 33 bits of the dividend must be
// below the divisor, so the quotient fits in 31 bits.
module cibs_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic [30:0] quotient
);

  localparam int N = cibs_pkg::DIV_STAGES;

  logic [32:0] rem_q [1:N-1];
  logic [30:0] lo_q  [1:N-1];
  logic [32:0] dv_q  [1:N-1];
  logic [30:0] q_q   [1:N];
  logic [32:0] rem_in [0:N-1];
  logic [30:0] lo_in  [0:N-1];
  logic [32:0] dv_in  [0:N-1];
  logic [30:0] q_in   [0:N-1];
  logic [32:0] rem_n  [0:N-1];
  logic [30:0] q_n    [0:N-1];

  // shift in one dividend bit and subtract where it fits
  always_comb begin
    logic [33:0] cand;
    logic        ge;
    rem_in[0] = dividend[63:31];
    lo_in[0]  = dividend[30:0];
    dv_in[0]  = divisor;
    q_in[0]   = '0;
    for (int i = 1; i < N; i++) begin
      rem_in[i] = rem_q[i];
      lo_in[i]  = lo_q[i];
      dv_in[i]  = dv_q[i];
      q_in[i]   = q_q[i];
    end
    for (int i = 0; i < N; i++) begin
      cand = {rem_in[i], lo_in[i][N-1-i]};
      ge   = cand >= {1'b0, dv_in[i]};
      if (ge) begin
        rem_n[i] = 33'(cand - {1'b0, dv_in[i]});
      end else begin
        rem_n[i] = cand[32:0];
      end
      q_n[i] = {q_in[i][29:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        q_q[i+1] <= q_n[i];
        if (i < N - 1) begin
          rem_q[i+1] <= rem_n[i];
          lo_q[i+1]  <= lo_in[i];
          dv_q[i+1]  <= dv_in[i];
        end
      end
    end
  end

  assign quotient = q_q[N];

endmodule
`default_nettype wire

/* src/circle_intersection_branch_select_top.sv */
// Circle-circle intersection with branch selection by Manhattan distance.
// Throughput: one request per cycle while the output is not stalled;
// the two square roots (32 stages each) and five dividers (31 stages
// each) are fully pipelined.
// Stall on the output holds every stage; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
`default_nettype none
module circle_intersection_branch_select_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] center1_x,
  input  logic signed [31:0] center1_y,
  input  logic signed [31:0] center2_x,
  input  logic signed [31:0] center2_y,
  input  logic        [30:0] radius1,
  input  logic        [30:0] radius2,
  input  logic signed [31:0] previous_x,
  input  logic signed [31:0] previous_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_x,
  output logic signed [31:0] result_y,
  output logic               found,
  output logic               picked_second
);

  localparam int SQ = cibs_pkg::SQRT_STAGES;
  localparam int DV = cibs_pkg::DIV_STAGES;

  typedef struct packed {
    logic               ok;
    logic        [63:0] nmag;
    logic               nneg;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] c1x;
    logic signed [31:0] c1y;
    logic        [30:0] r1;
    logic        [61:0] r1sq;
    logic signed [31:0] prx;
    logic signed [31:0] pry;
  } side_a_t;

  typedef struct packed {
    logic               ok;
    logic               sat;
    logic        [31:0] d;
    logic               nneg;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] c1x;
    logic signed [31:0] c1y;
    logic        [30:0] r1;
    logic        [61:0] r1sq;
    logic signed [31:0] prx;
    logic signed [31:0] pry;
  } side_b_t;

  typedef struct packed {
    logic               ok;
    logic        [30:0] amag;
    logic               nneg;
    logic        [31:0] d;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] c1x;
    logic signed [31:0] c1y;
    logic        [61:0] r1sq;
    logic signed [31:0] prx;
    logic signed [31:0] pry;
  } side_c_t;

  typedef struct packed {
    logic               ok;
    logic               neg_ax;
    logic               neg_ay;
    logic               neg_dx;
    logic               neg_dy;
    logic signed [31:0] c1x;
    logic signed [31:0] c1y;
    logic signed [31:0] prx;
    logic signed [31:0] pry;
  } side_d_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  logic adv;

  // one enable for the whole pipe: move unless the result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: capture request, center differences
  logic               v1;
  logic signed [31:0] s1_c1x, s1_c1y, s1_prx, s1_pry;
  logic signed [32:0] s1_dx, s1_dy;
  logic        [30:0] s1_r1, s1_r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_c1x <= center1_x;
      s1_c1y <= center1_y;
      s1_prx <= previous_x;
      s1_pry <= previous_y;
      s1_dx  <= {center2_x[31], center2_x} - {center1_x[31], center1_x};
      s1_dy  <= {center2_y[31], center2_y} - {center1_y[31], center1_y};
      s1_r1  <= radius1;
      s1_r2  <= radius2;
    end
  end

  // stage 2: squares of distances and radii, radius sum and difference
  logic               v2;
  logic        [63:0] s2_sx, s2_sy;
  logic        [61:0] s2_r1sq, s2_r2sq;
  logic        [31:0] s2_rsum;
  logic        [30:0] s2_rdif;
  logic signed [32:0] s2_dx, s2_dy;
  logic signed [31:0] s2_c1x, s2_c1y, s2_prx, s2_pry;
  logic        [30:0] s2_r1;
  logic        [32:0] s2_ux_m, s2_uy_m;

  assign s2_ux_m = mag33(s1_dx);
  assign s2_uy_m = mag33(s1_dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sx   <= s2_ux_m[31:0] * s2_ux_m[31:0];
      s2_sy   <= s2_uy_m[31:0] * s2_uy_m[31:0];
      s2_r1sq <= s1_r1 * s1_r1;
      s2_r2sq <= s1_r2 * s1_r2;
      s2_rsum <= {1'b0, s1_r1} + {1'b0, s1_r2};
      s2_rdif <= (s1_r1 >= s1_r2) ? s1_r1 - s1_r2 : s1_r2 - s1_r1;
      s2_dx   <= s1_dx;
      s2_dy   <= s1_dy;
      s2_c1x  <= s1_c1x;
      s2_c1y  <= s1_c1y;
      s2_prx  <= s1_prx;
      s2_pry  <= s1_pry;
      s2_r1   <= s1_r1;
    end
  end

  // stage 3: squared center distance and squared radius bounds
  logic               v3;
  logic        [64:0] s3_d2;
  logic        [63:0] s3_rsum2;
  logic        [61:0] s3_rdif2;
  logic        [61:0] s3_r1sq, s3_r2sq;
  logic signed [32:0] s3_dx, s3_dy;
  logic signed [31:0] s3_c1x, s3_c1y, s3_prx, s3_pry;
  logic        [30:0] s3_r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_d2    <= {1'b0, s2_sx} + {1'b0, s2_sy};
      s3_rsum2 <= s2_rsum * s2_rsum;
      s3_rdif2 <= s2_rdif * s2_rdif;
      s3_r1sq  <= s2_r1sq;
      s3_r2sq  <= s2_r2sq;
      s3_dx    <= s2_dx;
      s3_dy    <= s2_dy;
      s3_c1x   <= s2_c1x;
      s3_c1y   <= s2_c1y;
      s3_prx   <= s2_prx;
      s3_pry   <= s2_pry;
      s3_r1    <= s2_r1;
    end
  end

  // stage 4: intersection test and numerator r1^2 - r2^2 + d^2
  logic        s4_ok;
  logic [63:0] s4_nmag;
  logic        s4_nneg;
  logic [61:0] s4_t;

  always_comb begin
    s4_ok = !s3_d2[64] && (s3_d2[63:0] != 64'd0) && (s3_d2[63:0] <= s3_rsum2) &&
            (s3_d2[63:0] >= {2'b00, s3_rdif2});
    s4_t    = s3_r2sq - s3_r1sq;
    s4_nneg = 1'b0;
    if (s3_r1sq >= s3_r2sq) begin
      s4_nmag = s3_d2[63:0] + {2'b00, 62'(s3_r1sq - s3_r2sq)};
    end else if (s3_d2[63:0] >= {2'b00, s4_t}) begin
      s4_nmag = s3_d2[63:0] - {2'b00, s4_t};
    end else begin
      s4_nmag = {2'b00, s4_t} - s3_d2[63:0];
      s4_nneg = 1'b1;
    end
  end

  side_a_t     sa_in;
  logic        va_in;
  logic [63:0] d2_r;
  side_a_t     sa [1:SQ];
  logic        va [1:SQ];
  logic [31:0] root_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      va_in <= 1'b0;
    end else if (adv) begin
      va_in <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_r       <= s3_d2[63:0];
      sa_in.ok   <= s4_ok;
      sa_in.nmag <= s4_nmag;
      sa_in.nneg <= s4_nneg;
      sa_in.dx   <= s3_dx;
      sa_in.dy   <= s3_dy;
      sa_in.c1x  <= s3_c1x;
      sa_in.c1y  <= s3_c1y;
      sa_in.r1   <= s3_r1;
      sa_in.r1sq <= s3_r1sq;
      sa_in.prx  <= s3_prx;
      sa_in.pry  <= s3_pry;
    end
  end

  // d = floor(sqrt(d2)); carry the rest alongside
  cibs_sqrt u_sqrt_d (
    .clk      (clk),
    .en       (adv),
    .radicand (d2_r),
    .root     (root_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= SQ; i++) begin
        va[i] <= 1'b0;
      end
    end else if (adv) begin
      va[1] <= va_in;
      for (int i = 1; i < SQ; i++) begin
        va[i+1] <= va[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa[1] <= sa_in;
      for (int i = 1; i < SQ; i++) begin
        sa[i+1] <= sa[i];
      end
    end
  end

  // stage 5: set up |a| = |N| / (2d), flag quotients beyond 31 bits
  side_b_t     sb_in;
  logic        vb_in;
  logic [63:0] diva_dvd;
  logic [32:0] diva_dvs;
  side_b_t     sb [1:DV];
  logic        vb [1:DV];
  logic [30:0] q_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb_in <= 1'b0;
    end else if (adv) begin
      vb_in <= va[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diva_dvd   <= sa[SQ].nmag;
      diva_dvs   <= {root_d, 1'b0};
      sb_in.ok   <= sa[SQ].ok;
      sb_in.sat  <= sa[SQ].nmag[63:31] >= {root_d, 1'b0};
      sb_in.d    <= root_d;
      sb_in.nneg <= sa[SQ].nneg;
      sb_in.dx   <= sa[SQ].dx;
      sb_in.dy   <= sa[SQ].dy;
      sb_in.c1x  <= sa[SQ].c1x;
      sb_in.c1y  <= sa[SQ].c1y;
      sb_in.r1   <= sa[SQ].r1;
      sb_in.r1sq <= sa[SQ].r1sq;
      sb_in.prx  <= sa[SQ].prx;
      sb_in.pry  <= sa[SQ].pry;
    end
  end

  cibs_div u_div_a (
    .clk      (clk),
    .en       (adv),
    .dividend (diva_dvd),
    .divisor  (diva_dvs),
    .quotient (q_a)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= DV; i++) begin
        vb[i] <= 1'b0;
      end
    end else if (adv) begin
      vb[1] <= vb_in;
      for (int i = 1; i < DV; i++) begin
        vb[i+1] <= vb[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[1] <= sb_in;
      for (int i = 1; i < DV; i++) begin
        sb[i+1] <= sb[i];
      end
    end
  end

  // stage 6: clamp |a| to r1
  side_c_t     c6;
  logic        v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= vb[DV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c6.ok   <= sb[DV].ok;
      c6.amag <= (sb[DV].sat || (q_a > sb[DV].r1)) ? sb[DV].r1 : q_a;
      c6.nneg <= sb[DV].nneg;
      c6.d    <= sb[DV].d;
      c6.dx   <= sb[DV].dx;
      c6.dy   <= sb[DV].dy;
      c6.c1x  <= sb[DV].c1x;
      c6.c1y  <= sb[DV].c1y;
      c6.r1sq <= sb[DV].r1sq;
      c6.prx  <= sb[DV].prx;
      c6.pry  <= sb[DV].pry;
    end
  end

  // stage 7: a^2
  side_c_t     c7;
  logic        v7;
  logic [61:0] asq7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c7   <= c6;
      asq7 <= c6.amag * c6.amag;
    end
  end

  // stage 8: h^2 = r1^2 - a^2, then h = floor(sqrt(h^2))
  side_c_t     sc_in;
  logic        vc_in;
  logic [61:0] hsq;
  side_c_t     sc [1:SQ];
  logic        vc [1:SQ];
  logic [31:0] root_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc_in <= 1'b0;
    end else if (adv) begin
      vc_in <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_in <= c7;
      hsq   <= c7.r1sq - asq7;
    end
  end

  cibs_sqrt u_sqrt_h (
    .clk      (clk),
    .en       (adv),
    .radicand ({2'b00, hsq}),
    .root     (root_h)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= SQ; i++) begin
        vc[i] <= 1'b0;
      end
    end else if (adv) begin
      vc[1] <= vc_in;
      for (int i = 1; i < SQ; i++) begin
        vc[i+1] <= vc[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc[1] <= sc_in;
      for (int i = 1; i < SQ; i++) begin
        sc[i+1] <= sc[i];
      end
    end
  end

  // stage 9: magnitudes of a*dx, a*dy, h*dx, h*dy
  side_d_t     sd_in;
  logic        vd_in;
  logic [62:0] p_ax, p_ay, p_hx, p_hy;
  logic [31:0] dd9;
  logic [32:0] s9_ux_m, s9_uy_m;
  side_d_t     sd [1:DV];
  logic        vd [1:DV];
  logic [30:0] q_ax, q_ay, q_hx, q_hy;

  assign s9_ux_m = mag33(sc[SQ].dx);
  assign s9_uy_m = mag33(sc[SQ].dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      vd_in <= 1'b0;
    end else if (adv) begin
      vd_in <= vc[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ax         <= sc[SQ].amag * s9_ux_m[31:0];
      p_ay         <= sc[SQ].amag * s9_uy_m[31:0];
      p_hx         <= root_h[30:0] * s9_ux_m[31:0];
      p_hy         <= root_h[30:0] * s9_uy_m[31:0];
      dd9          <= sc[SQ].d;
      sd_in.ok     <= sc[SQ].ok;
      sd_in.neg_ax <= sc[SQ].nneg ^ sc[SQ].dx[32];
      sd_in.neg_ay <= sc[SQ].nneg ^ sc[SQ].dy[32];
      sd_in.neg_dx <= sc[SQ].dx[32];
      sd_in.neg_dy <= sc[SQ].dy[32];
      sd_in.c1x    <= sc[SQ].c1x;
      sd_in.c1y    <= sc[SQ].c1y;
      sd_in.prx    <= sc[SQ].prx;
      sd_in.pry    <= sc[SQ].pry;
    end
  end

  // divide all four products by d in parallel
  cibs_div u_div_ax (
    .clk (clk), .en (adv), .dividend ({1'b0, p_ax}), .divisor ({1'b0, dd9}),
    .quotient (q_ax)
  );

  cibs_div u_div_ay (
    .clk (clk), .en (adv), .dividend ({1'b0, p_ay}), .divisor ({1'b0, dd9}),
    .quotient (q_ay)
  );

  cibs_div u_div_hx (
    .clk (clk), .en (adv), .dividend ({1'b0, p_hx}), .divisor ({1'b0, dd9}),
    .quotient (q_hx)
  );

  cibs_div u_div_hy (
    .clk (clk), .en (adv), .dividend ({1'b0, p_hy}), .divisor ({1'b0, dd9}),
    .quotient (q_hy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= DV; i++) begin
        vd[i] <= 1'b0;
      end
    end else if (adv) begin
      vd[1] <= vd_in;
      for (int i = 1; i < DV; i++) begin
        vd[i+1] <= vd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[1] <= sd_in;
      for (int i = 1; i < DV; i++) begin
        sd[i+1] <= sd[i];
      end
    end
  end

  // stage 10: restore signs, base point p = c1 + a*(dx,dy)/d
  logic signed [32:0] s10_ax, s10_ay, s10_hx, s10_hy;
  logic               v10;
  logic               ok10;
  logic signed [33:0] px10, py10;
  logic signed [32:0] hx10, hy10;
  logic signed [31:0] prx10, pry10;

  always_comb begin
    s10_ax = sd[DV].neg_ax ? -$signed({2'b00, q_ax}) : $signed({2'b00, q_ax});
    s10_ay = sd[DV].neg_ay ? -$signed({2'b00, q_ay}) : $signed({2'b00, q_ay});
    s10_hx = sd[DV].neg_dx ? -$signed({2'b00, q_hx}) : $signed({2'b00, q_hx});
    s10_hy = sd[DV].neg_dy ? -$signed({2'b00, q_hy}) : $signed({2'b00, q_hy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (adv) begin
      v10 <= vd[DV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px10  <= $signed({{2{sd[DV].c1x[31]}}, sd[DV].c1x}) + $signed({s10_ax[32], s10_ax});
      py10  <= $signed({{2{sd[DV].c1y[31]}}, sd[DV].c1y}) + $signed({s10_ay[32], s10_ay});
      hx10  <= s10_hx;
      hy10  <= s10_hy;
      ok10  <= sd[DV].ok;
      prx10 <= sd[DV].prx;
      pry10 <= sd[DV].pry;
    end
  end

  // stage 11: both intersection points, saturated
  logic               v11;
  logic               ok11;
  logic signed [31:0] p1x, p1y, p2x, p2y;
  logic signed [31:0] prx11, pry11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (adv) begin
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1x   <= sat32($signed({px10[33], px10}) + $signed({{2{hy10[32]}}, hy10}));
      p1y   <= sat32($signed({py10[33], py10}) - $signed({{2{hx10[32]}}, hx10}));
      p2x   <= sat32($signed({px10[33], px10}) - $signed({{2{hy10[32]}}, hy10}));
      p2y   <= sat32($signed({py10[33], py10}) + $signed({{2{hx10[32]}}, hx10}));
      ok11  <= ok10;
      prx11 <= prx10;
      pry11 <= pry10;
    end
  end

  // stage 12: Manhattan distance of each point to the previous one
  logic               v12;
  logic               ok12;
  logic        [33:0] m1, m2;
  logic signed [31:0] q1x, q1y, q2x, q2y;
  logic signed [31:0] prx12, pry12;
  logic        [32:0] e1x, e1y, e2x, e2y;

  always_comb begin
    e1x = mag33($signed({prx11[31], prx11}) - $signed({p1x[31], p1x}));
    e1y = mag33($signed({pry11[31], pry11}) - $signed({p1y[31], p1y}));
    e2x = mag33($signed({prx11[31], prx11}) - $signed({p2x[31], p2x}));
    e2y = mag33($signed({pry11[31], pry11}) - $signed({p2y[31], p2y}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
    end else if (adv) begin
      v12 <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1    <= {1'b0, e1x} + {1'b0, e1y};
      m2    <= {1'b0, e2x} + {1'b0, e2y};
      q1x   <= p1x;
      q1y   <= p1y;
      q2x   <= p2x;
      q2y   <= p2y;
      ok12  <= ok11;
      prx12 <= prx11;
      pry12 <= pry11;
    end
  end

  // stage 13: nearer point, first on tie; no hit: previous; hold on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v12;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!ok12) begin
        result_x      <= prx12;
        result_y      <= pry12;
        found         <= 1'b0;
        picked_second <= 1'b0;
      end else if (m1 > m2) begin
        result_x      <= q2x;
        result_y      <= q2y;
        found         <= 1'b1;
        picked_second <= 1'b1;
      end else begin
        result_x      <= q1x;
        result_y      <= q1y;
        found         <= 1'b1;
        picked_second <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
